// File: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ADDR_W  = 20;
    localparam int LIMIT_W = 21;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 21'd1048576;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 24;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED   = 3'd0,
        ST_APPENDED = 3'd1,
        ST_ZERO     = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_FULL     = 3'd4,
        ST_FREED    = 3'd5,
        ST_RELEASED = 3'd6,
        ST_UNKNOWN  = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_TRIVIAL
    } t_state;

    // one table entry: header offset, payload size, free flag
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic              free;
    } t_entry;

    typedef struct packed {
        logic start;
        logic scan;
        logic fin_hit;
        logic fin_miss;
        logic fin_trivial;
    } t_dp_cmd;

    typedef struct packed {
        logic in_trivial;
        logic empty;
        logic hit;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: sv/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_if
// Valid/ready channels of the allocator: request, response, configuration.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [19:0] req_size;
    logic [19:0] block_address;

    modport source (output valid, req_type, req_size, block_address, input ready);
    modport sink   (input valid, req_type, req_size, block_address, output ready);
endinterface

interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [19:0] result_address;
    logic [2:0]  status;

    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

interface ffba_cfg_if;
    logic        valid;
    logic        ready;
    logic [20:0] heap_limit;

    modport source (output valid, heap_limit, input ready);
    modport sink   (input valid, heap_limit, output ready);
endinterface

// File: sv/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_table
    import ffba_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_BLOCKS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Allocator datapath: request and limit registers, break and block count,
// scan pointer, entry compare, table update and result register.
// ----------------------------------------------------------------------------
module ffba_datapath
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_req_type,
    input  logic [ADDR_W-1:0]   i_req_size,
    input  logic [ADDR_W-1:0]   i_block_address,
    input  logic                i_cfg_valid,
    input  logic [LIMIT_W-1:0]  i_cfg_heap_limit,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ADDR_W-1:0]   o_result_address,
    output t_status             o_status
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [LIMIT_W-1:0] HDR     = LIMIT_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_BLOCKS);

    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic [LIMIT_W-1:0] r_break, n_break;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic               r_type, n_type;
    logic [ADDR_W-1:0]  r_size, n_size;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    t_status            r_out_status, n_out_status;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_entry             w_wdata;
    logic               w_issue;
    t_entry             w_rd;

    logic               w_hit;
    logic               w_scan_done;
    logic               w_out_free;
    logic               w_is_top;
    logic [LIMIT_W-1:0] w_total;
    logic [LIMIT_W:0]   w_need;
    logic               w_nospace;
    logic [LIMIT_W-1:0] w_hit_off;
    logic [LIMIT_W-1:0] w_brk_off;

    ffba_table #(
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rd)
    );

    always_comb begin
        w_hit_off   = {1'b0, w_rd.base} + HDR;
        w_brk_off   = r_break + HDR;
        w_scan_done = (r_idx == r_count);
        w_out_free  = !r_out_valid || i_out_ready;
        if (r_type == REQ_ALLOC) begin
            w_hit = r_chk_valid && w_rd.free && (w_rd.size >= r_size);
        end else begin
            w_hit = r_chk_valid && (w_hit_off == {1'b0, r_addr});
        end
        // hold the read data once a hit is seen
        w_issue   = i_cmd.scan && !w_scan_done && !w_hit;
        w_is_top  = (({1'b0, r_addr} + {1'b0, w_rd.size}) == r_break);
        w_total   = {1'b0, r_size} + HDR;
        w_need    = {1'b0, r_break} + {1'b0, w_total};
        w_nospace = (w_need > {1'b0, r_limit});
    end

    always_comb begin
        o_sts.in_trivial = (i_req_type == REQ_ALLOC) ? (i_req_size == '0)
                                                     : (i_block_address == '0);
        o_sts.empty      = (r_count == '0);
        o_sts.hit        = w_hit;
        o_sts.scan_done  = w_scan_done;
        o_sts.out_free   = w_out_free;
    end

    always_comb begin
        n_limit      = r_limit;
        n_break      = r_break;
        n_count      = r_count;
        n_idx        = r_idx;
        n_chk_valid  = w_issue;
        n_chk_idx    = r_chk_idx;
        n_type       = r_type;
        n_size       = r_size;
        n_addr       = r_addr;
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_chk_idx;
        w_wdata      = w_rd;

        if (i_cfg_valid) begin
            n_limit = (i_cfg_heap_limit > LIMIT_MAX) ? LIMIT_MAX : i_cfg_heap_limit;
        end

        if (i_cmd.start) begin
            n_type = i_req_type;
            n_size = i_req_size;
            n_addr = i_block_address;
            n_idx  = '0;
        end

        if (w_issue) begin
            n_chk_idx = r_idx[IDX_W-1:0];
            n_idx     = r_idx + CNT_W'(1);
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.fin_trivial) begin
            n_out_valid  = 1'b1;
            n_out_addr   = '0;
            n_out_status = (r_type == REQ_FREE) ? ST_UNKNOWN : ST_ZERO;
        end

        if (i_cmd.fin_hit) begin
            n_out_valid = 1'b1;
            n_out_addr  = '0;
            if (r_type == REQ_ALLOC) begin
                w_we         = 1'b1;
                w_wdata.free = 1'b0;
                n_out_addr   = w_hit_off[ADDR_W-1:0];
                n_out_status = ST_REUSED;
            end else if (w_is_top) begin
                // drop the top block and lower the break
                n_break      = r_break - ({1'b0, w_rd.size} + HDR);
                n_count      = r_count - CNT_W'(1);
                n_out_status = ST_RELEASED;
            end else begin
                w_we         = 1'b1;
                w_wdata.free = 1'b1;
                n_out_status = ST_FREED;
            end
        end

        if (i_cmd.fin_miss) begin
            n_out_valid = 1'b1;
            n_out_addr  = '0;
            if (r_type == REQ_FREE) begin
                n_out_status = ST_UNKNOWN;
            end else if (w_nospace) begin
                n_out_status = ST_NOSPACE;
            end else if (r_count == CNT_MAX) begin
                n_out_status = ST_FULL;
            end else begin
                // append a block at the break
                w_we         = 1'b1;
                w_waddr      = r_count[IDX_W-1:0];
                w_wdata.base = r_break[ADDR_W-1:0];
                w_wdata.size = r_size;
                w_wdata.free = 1'b0;
                n_count      = r_count + CNT_W'(1);
                n_break      = w_need[LIMIT_W-1:0];
                n_out_addr   = w_brk_off[ADDR_W-1:0];
                n_out_status = ST_APPENDED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_MAX;
            r_break     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_limit     <= n_limit;
            r_break     <= n_break;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_type       <= n_type;
        r_size       <= n_size;
        r_addr       <= n_addr;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

endmodule

// File: sv/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Allocator controller: accepts a request, runs the table scan and picks
// the finishing action once the result register is free.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_sts.in_trivial) begin
                        n_state = S_TRIVIAL;
                    end else if (i_sts.empty) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_HIT;
                end else if (i_sts.scan_done) begin
                    n_state = S_MISS;
                end
            end
            S_HIT: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_hit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MISS: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_miss = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TRIVIAL: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_trivial = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an address-ordered block table.
// ----------------------------------------------------------------------------
// One request is in work at a time. A zero-size allocate or a null free
// skips the walk: the controller goes to its trivial state, writes the
// result register and returns to idle, where the next request can be taken.
// Any other request walks the block table one entry per cycle through the
// table's single read port, reading at most as many entries as the block
// count (MAX_BLOCKS at most). A hit ends the walk early, and an empty table
// skips the walk and goes straight to the miss state. The result waits in an
// output register, and the next request is taken as soon as the controller
// is back in idle. A stalled result holds the controller only when a new
// result is ready to be written behind it. The table needs no clearing after
// reset: only entries below the block count are ever read. heap_limit may be
// written only while no request is in work.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ffba_req_if.sink   i_req,
    ffba_rsp_if.source o_rsp,
    ffba_cfg_if.sink   i_cfg
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_req_ready;
    t_status w_status;

    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ffba_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_type       (i_req.req_type),
        .i_req_size       (i_req.req_size),
        .i_block_address  (i_req.block_address),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_heap_limit (i_cfg.heap_limit),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_result_address (o_rsp.result_address),
        .o_status         (w_status)
    );

    assign i_req.ready  = w_req_ready;
    assign i_cfg.ready  = 1'b1;
    assign o_rsp.status = w_status;

endmodule

// File: tb/tb_first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A directed table runs
// the edge cases first, then constrained-random phases at several heap limits.
// A shadow of the block table predicts every response. The request side is
// driven in random bursts, and the response side stalls on a rolling pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int NBLK         = DEF_MAX_BLOCKS;
    localparam int HDR          = DEF_HEADER_BYTES;
    localparam int DRAIN_CYCLES = NBLK + 8;

    typedef struct {
        logic              typ;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                known;
        logic [ADDR_W-1:0] want_addr;
        t_status           want_st;
    } t_row;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           st;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();
    ffba_cfg_if cfg_ch ();

    first_fit_block_allocator #(
        .MAX_BLOCKS  (NBLK),
        .HEADER_BYTES(HDR)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    // shadow of the heap
    int unsigned       limit_sh;
    logic [ADDR_W-1:0] blk_base [NBLK];
    logic [ADDR_W-1:0] blk_size [NBLK];
    bit                blk_free [NBLK];
    int unsigned       blk_cnt;
    int unsigned       brk_sh;

    t_outcome outcome_q[$];
    t_row     plan[$];
    int       mism;
    int       burst_left;
    int       max_gap;
    int       stall_mode;

    function automatic t_outcome heap_predict(logic typ, logic [ADDR_W-1:0] size,
                                              logic [ADDR_W-1:0] addr);
        t_outcome    o;
        int unsigned need;
        int unsigned k;
        bit          hit;
        o.addr = '0;
        hit    = 0;
        if (typ == REQ_ALLOC) begin
            if (size == 0) begin
                o.st = ST_ZERO;
            end else begin
                for (k = 0; k < blk_cnt && !hit; k++) begin
                    if (blk_free[k] && blk_size[k] >= size) begin
                        blk_free[k] = 0;
                        o.addr      = ADDR_W'(blk_base[k] + HDR);
                        o.st        = ST_REUSED;
                        hit         = 1;
                    end
                end
                if (!hit) begin
                    need = HDR + size;
                    if (brk_sh > limit_sh || need > limit_sh - brk_sh) begin
                        o.st = ST_NOSPACE;
                    end else if (blk_cnt >= NBLK) begin
                        o.st = ST_FULL;
                    end else begin
                        blk_base[blk_cnt] = ADDR_W'(brk_sh);
                        blk_size[blk_cnt] = size;
                        blk_free[blk_cnt] = 0;
                        o.addr            = ADDR_W'(brk_sh + HDR);
                        o.st              = ST_APPENDED;
                        blk_cnt++;
                        brk_sh += need;
                    end
                end
            end
        end else begin
            o.st = ST_UNKNOWN;
            if (addr != 0) begin
                for (k = 0; k < blk_cnt && !hit; k++) begin
                    if (blk_base[k] + HDR == addr) begin
                        hit = 1;
                        if (int'(addr) + int'(blk_size[k]) == brk_sh) begin
                            // top block: drop it and pull the break down
                            brk_sh -= HDR + blk_size[k];
                            blk_cnt--;
                            o.st = ST_RELEASED;
                        end else begin
                            blk_free[k] = 1;
                            o.st        = ST_FREED;
                        end
                    end
                end
            end
        end
        return o;
    endfunction

    function automatic t_row row(logic typ, logic [ADDR_W-1:0] size,
                                 logic [ADDR_W-1:0] addr, bit known,
                                 logic [ADDR_W-1:0] want_addr, t_status want_st);
        t_row r;
        r.typ       = typ;
        r.size      = size;
        r.addr      = addr;
        r.known     = known;
        r.want_addr = want_addr;
        r.want_st   = want_st;
        return r;
    endfunction

    // random request: well-formed allocs and frees of live blocks, plus noise
    function automatic t_row make_item(int p_alloc, int p_free);
        t_row        r;
        int          roll;
        int          pick;
        int unsigned k;
        r       = row(REQ_ALLOC, ADDR_W'($urandom), ADDR_W'($urandom), 0, '0, ST_ZERO);
        roll    = $urandom_range(0, 99);
        if (roll < p_alloc) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                r.size = ADDR_W'($urandom_range(1, 256));
            end else if (pick < 85) begin
                r.size = ADDR_W'($urandom_range(1, 4096));
            end else if (pick < 93 && blk_cnt > 0) begin
                // hit a block size exactly or just miss it
                k      = $urandom_range(0, blk_cnt - 1);
                r.size = blk_size[k] + ADDR_W'($urandom_range(0, 1));
            end
        end else if (roll < p_alloc + p_free && blk_cnt > 0) begin
            k      = $urandom_range(0, blk_cnt - 1);
            r.typ  = REQ_FREE;
            r.addr = ADDR_W'(blk_base[k] + HDR);
        end else begin
            case ($urandom_range(0, 3))
                0: r.size = '0;
                1: begin
                    r.typ  = REQ_FREE;
                    r.addr = '0;
                end
                2: r.typ = REQ_FREE;
                default: begin
                    r.typ = REQ_FREE;
                    if (blk_cnt > 0) begin
                        k      = $urandom_range(0, blk_cnt - 1);
                        r.addr = ADDR_W'(blk_base[k] + HDR + ($urandom_range(0, 1) ? 1 : -1));
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic send_item(t_row r);
        t_outcome o;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (max_gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.typ;
        req_ch.req_size      <= r.size;
        req_ch.block_address <= r.addr;
        do @(posedge i_clk); while (!req_ch.ready);
        o = heap_predict(r.typ, r.size, r.addr);
        if (r.known) begin
            o.addr = r.want_addr;
            o.st   = r.want_st;
        end
        outcome_q.push_back(o);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        // hold requests and let the block drain before touching the register
        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.heap_limit <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_sh     = (v > LIMIT_MAX) ? LIMIT_MAX : v;
    endtask

    task automatic run_phase(int n, int p_alloc, int p_free, int gap, int stall);
        max_gap    = gap;
        stall_mode = stall;
        repeat (n) send_item(make_item(p_alloc, p_free));
    endtask

    task automatic note_bad(string field, int want, int got);
        mism++;
        if (mism <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** first_fit_block_allocator: FAILED **");
        $finish;
    end

    // response side: check each item, then pick the next ready value
    initial begin : rsp_side
        logic [15:0] pat;
        int          ph;
        t_outcome    w;
        rsp_ch.ready <= 1'b0;
        pat = '1;
        ph  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (outcome_q.size() == 0) begin
                    note_bad("unexpected item, status", -1, rsp_ch.status);
                end else begin
                    w = outcome_q.pop_front();
                    if (rsp_ch.result_address !== w.addr)
                        note_bad("result_address", w.addr, rsp_ch.result_address);
                    if (rsp_ch.status !== w.st)
                        note_bad("status", w.st, rsp_ch.status);
                end
            end
            ph = (ph + 1) % 16;
            if (ph == 0) begin
                case ($urandom_range(0, 3))
                    0: pat = '1;
                    1: pat = 16'($urandom);
                    2: pat = 16'($urandom | $urandom);
                    default: pat = 16'($urandom & $urandom) | 16'h0001;
                endcase
            end
            rsp_ch.ready <= (stall_mode == 0) ? 1'b1 : pat[ph];
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_ALLOC;
        req_ch.req_size      <= '0;
        req_ch.block_address <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.heap_limit    <= LIMIT_MAX;
        limit_sh   = LIMIT_MAX;
        blk_cnt    = 0;
        brk_sh     = 0;
        mism       = 0;
        burst_left = 0;
        max_gap    = 3;
        stall_mode = 1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // edge cases from reset, heap limit at its reset value
        plan.push_back(row(REQ_ALLOC, 20'd0,       20'd0,       1, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd0,       1, 20'd0,  ST_UNKNOWN));
        plan.push_back(row(REQ_FREE,  20'd0,       20'hFFFFF,   1, 20'd0,  ST_UNKNOWN));
        plan.push_back(row(REQ_ALLOC, 20'd1048553, 20'd0,       1, 20'd0,  ST_NOSPACE));
        plan.push_back(row(REQ_ALLOC, 20'd1048552, 20'd0,       1, 20'd24, ST_APPENDED));
        plan.push_back(row(REQ_ALLOC, 20'd1,       20'd0,       1, 20'd0,  ST_NOSPACE));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd24,      1, 20'd0,  ST_RELEASED));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd24,      1, 20'd0,  ST_UNKNOWN));
        plan.push_back(row(REQ_ALLOC, 20'd1,       20'd0,       1, 20'd24, ST_APPENDED));
        plan.push_back(row(REQ_ALLOC, 20'hFFFFF,   20'd0,       1, 20'd0,  ST_NOSPACE));
        plan.push_back(row(REQ_ALLOC, 20'd100,     20'd0,       0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_ALLOC, 20'd8,       20'd0,       0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd49,      0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd49,      0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_ALLOC, 20'd101,     20'd0,       0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_ALLOC, 20'd100,     20'd0,       0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd50,      1, 20'd0,  ST_UNKNOWN));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd205,     0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd24,      0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_ALLOC, 20'd1,       20'd0,       0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd173,     0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd49,      0, 20'd0,  ST_ZERO));
        plan.push_back(row(REQ_FREE,  20'd0,       20'd24,      0, 20'd0,  ST_ZERO));
        foreach (plan[i]) send_item(plan[i]);

        // fill the table to the brim, first without any idling
        write_limit(LIMIT_MAX);
        run_phase(60, 85, 10, 0, 0);
        run_phase(90, 80, 10, 4, 1);
        // limit dropped to or under the current break
        write_limit(LIMIT_W'($urandom_range(0, brk_sh)));
        run_phase(80, 45, 45, 5, 1);
        write_limit(LIMIT_W'($urandom_range(1000, 20000)));
        run_phase(150, 50, 40, 6, 1);
        write_limit('0);
        run_phase(50, 50, 40, 2, 1);
        // oversized write saturates to the top
        write_limit('1);
        run_phase(120, 30, 60, 8, 1);

        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mism == 0 && outcome_q.size() == 0) begin
            $display("** first_fit_block_allocator: PASSED **");
        end else begin
            $display("** first_fit_block_allocator: FAILED **");
        end
        $finish;
    end

endmodule

// File: first_fit_block_allocator.f
sv/ffba_pkg.sv
sv/ffba_if.sv
sv/ffba_table.sv
sv/ffba_datapath.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator.sv
tb/tb_first_fit_block_allocator.sv
